[rtl/tq_pkg.sv]
// Shared types and constants for the timer queue.
package tq_pkg;

    localparam int TIMER_SLOTS_DEFAULT = 16;

    localparam int TIME_W   = 48;
    localparam int ID_W     = 32;
    localparam int PERIOD_W = 32;
    localparam int SCALE_W  = 20;
    localparam int PROD_W   = PERIOD_W + SCALE_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1000);

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD_ACK = 2'd0;
    localparam logic [1:0] KIND_RM_ACK  = 2'd1;
    localparam logic [1:0] KIND_FIRE    = 2'd2;
    localparam logic [1:0] KIND_DONE    = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [TIME_W-1:0]   expiration;
        logic [PERIOD_W-1:0] period;
    } tq_entry_t;

endpackage

[rtl/tq_mem.sv]
// Timer slot memory: one write port, one read port, registered read data.
module tq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  tq_pkg::tq_entry_t   wr_data,
    input  logic [AW-1:0]       rd_addr,
    output tq_pkg::tq_entry_t   rd_data
);
    import tq_pkg::*;

    tq_entry_t mem [DEPTH];
    tq_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/timer_queue_oneshot_periodic.sv]
// Timer queue top level: slot table, scan sequencer, rearm arithmetic, result register.
//
// A table of TIMER_SLOTS one-shot or periodic timers. Slot contents (id, expiration,
// period) live in a single-port-write memory with a registered read; per-slot valid
// bits are flops cleared by reset, so no clearing pass is needed. An add finishes
// in the cycle it is accepted (lowest free slot from the valid bits) and answers
// one word. A remove reads every slot once. A tick runs one full read pass of the
// memory per fired timer to pick the earliest (expiration, then lowest id) due timer,
// fires it, frees it if one-shot or rearms it with a registered period*scale multiply
// and a saturating add, then runs one pass that finds nothing more due and one more
// pass for the next pending expiration. Each input item is handled alone; the next
// is taken once its last result word is in the output register and that register
// is free. Results may stall on m_ready without losing words. period_scale is
// written on the cfg port, always ready.
module timer_queue_oneshot_periodic #(
    parameter int TIMER_SLOTS = tq_pkg::TIMER_SLOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tq_pkg::SCALE_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [tq_pkg::TIME_W-1:0]     s_expire_at,
    input  logic [tq_pkg::PERIOD_W-1:0]   s_period_ms,
    input  logic [tq_pkg::ID_W-1:0]       s_target_id,
    input  logic [tq_pkg::TIME_W-1:0]     s_current_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [tq_pkg::ID_W-1:0]       m_timer_id,
    output logic [1:0]                    m_status,
    output logic [tq_pkg::TIME_W-1:0]     m_next_expiration,
    output logic                          m_next_valid,
    output logic                          m_last
);
    import tq_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RM_SCAN, ST_RM_DONE, ST_TK_SCAN, ST_TK_FIRE,
        ST_TK_MUL, ST_TK_WR, ST_NX_SCAN, ST_TK_DONE
    } state_t;

    state_t                 state_reg;
    logic [SCALE_W-1:0]     scale_reg;
    logic [TIMER_SLOTS-1:0] valid_reg;
    logic [TIMER_SLOTS-1:0] fired_reg;
    logic [ID_W-1:0]        id_ctr_reg;
    logic [ID_W-1:0]        target_reg;
    logic [TIME_W-1:0]      now_reg;

    // scan pipeline: address counter, then one stage matching the memory latency
    logic [CNT_W-1:0]       cnt_reg;
    logic                   pipe_v_reg;
    logic [IDX_W-1:0]       pipe_idx_reg;

    // running best candidate of a scan
    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [ID_W-1:0]        best_id_reg;
    logic [TIME_W-1:0]      best_exp_reg;
    logic [PERIOD_W-1:0]    best_period_reg;
    logic [PROD_W-1:0]      prod_reg;

    // result register
    logic                   m_valid_reg;
    logic [1:0]             m_kind_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic [1:0]             m_status_reg;
    logic [TIME_W-1:0]      m_nexp_reg;
    logic                   m_nvalid_reg;
    logic                   m_last_reg;

    logic                   out_free;
    logic                   out_load;
    logic                   in_acc;
    logic                   scan_more;
    logic                   scan_end;
    logic                   take;
    logic                   free_any;
    logic [IDX_W-1:0]       free_idx;
    logic [ID_W-1:0]        id_next;
    logic [PROD_W:0]        sum;
    logic [TIME_W-1:0]      rearm_exp;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    tq_entry_t              mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    tq_entry_t              rd_entry;

    tq_mem #(
        .DEPTH (TIMER_SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (rd_entry)
    );

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign in_acc    = s_valid && s_ready;

    // a new word enters the result register this cycle
    assign out_load  = (in_acc && (s_mode == MODE_ADD))
                    || (out_free && ((state_reg == ST_RM_DONE) || (state_reg == ST_TK_FIRE)
                                     || (state_reg == ST_TK_DONE)));

    assign scan_more = cnt_reg != CNT_W'(TIMER_SLOTS);
    assign scan_end  = !scan_more && !pipe_v_reg;
    assign mem_raddr = scan_more ? cnt_reg[IDX_W-1:0] : '0;

    // lowest free slot
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign id_next = (id_ctr_reg == '1) ? ID_W'(1) : id_ctr_reg + ID_W'(1);

    // rearm time, saturating at the top of the time range
    assign sum       = {{(PROD_W + 1 - TIME_W){1'b0}}, now_reg} + {1'b0, prod_reg};
    assign rearm_exp = (sum[PROD_W:TIME_W] != '0) ? '1 : sum[TIME_W-1:0];

    // candidate test on the word coming out of memory
    always_comb begin
        take = 1'b0;
        if (pipe_v_reg && valid_reg[pipe_idx_reg]) begin
            unique case (state_reg)
                ST_RM_SCAN: take = !found_reg && (rd_entry.id == target_reg);
                ST_TK_SCAN: take = !fired_reg[pipe_idx_reg]
                                && (rd_entry.expiration <= now_reg)
                                && (!found_reg
                                    || (rd_entry.expiration < best_exp_reg)
                                    || ((rd_entry.expiration == best_exp_reg)
                                        && (rd_entry.id < best_id_reg)));
                ST_NX_SCAN: take = !found_reg || (rd_entry.expiration < best_exp_reg);
                default:    take = 1'b0;
            endcase
        end
    end

    // memory write: new timer on add, rearmed expiration on tick
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = '{id: best_id_reg, expiration: rearm_exp, period: best_period_reg};
        if (state_reg == ST_TK_WR) begin
            mem_we = 1'b1;
        end else if (in_acc && (s_mode == MODE_ADD) && free_any) begin
            mem_we    = 1'b1;
            mem_waddr = free_idx;
            mem_wdata = '{id: id_next, expiration: s_expire_at, period: s_period_ms};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            scale_reg   <= SCALE_RESET;
            valid_reg   <= '0;
            fired_reg   <= '0;
            id_ctr_reg  <= '0;
            cnt_reg     <= '0;
            pipe_v_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                scale_reg <= cfg_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // scan address and pipeline stage
            if (state_reg == ST_RM_SCAN || state_reg == ST_TK_SCAN
                    || state_reg == ST_NX_SCAN) begin
                pipe_v_reg   <= scan_more;
                pipe_idx_reg <= cnt_reg[IDX_W-1:0];
                if (scan_more) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (take) begin
                    found_reg       <= 1'b1;
                    best_idx_reg    <= pipe_idx_reg;
                    best_id_reg     <= rd_entry.id;
                    best_exp_reg    <= rd_entry.expiration;
                    best_period_reg <= rd_entry.period;
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg    <= '0;
                    pipe_v_reg <= 1'b0;
                    found_reg  <= 1'b0;
                    if (in_acc) begin
                        target_reg <= s_target_id;
                        now_reg    <= s_current_time;
                        fired_reg  <= '0;
                        unique case (s_mode)
                            MODE_ADD: begin
                                m_kind_reg   <= KIND_ADD_ACK;
                                m_nexp_reg   <= '0;
                                m_nvalid_reg <= 1'b0;
                                m_last_reg   <= 1'b1;
                                if (free_any) begin
                                    valid_reg[free_idx] <= 1'b1;
                                    id_ctr_reg          <= id_next;
                                    m_id_reg            <= id_next;
                                    m_status_reg        <= STAT_OK;
                                end else begin
                                    m_id_reg     <= '0;
                                    m_status_reg <= STAT_FULL;
                                end
                            end
                            MODE_REMOVE: state_reg <= ST_RM_SCAN;
                            MODE_TICK:   state_reg <= ST_TK_SCAN;
                            default:     state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RM_SCAN: begin
                    if (scan_end) begin
                        state_reg <= ST_RM_DONE;
                    end
                end
                ST_RM_DONE: begin
                    if (out_free) begin
                        m_kind_reg   <= KIND_RM_ACK;
                        m_id_reg     <= target_reg;
                        m_status_reg <= found_reg ? STAT_OK : STAT_UNKNOWN;
                        m_nexp_reg   <= '0;
                        m_nvalid_reg <= 1'b0;
                        m_last_reg   <= 1'b1;
                        if (found_reg) begin
                            valid_reg[best_idx_reg] <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TK_SCAN: begin
                    if (scan_end) begin
                        if (found_reg) begin
                            state_reg <= ST_TK_FIRE;
                        end else begin
                            cnt_reg   <= '0;
                            state_reg <= ST_NX_SCAN;
                        end
                    end
                end
                ST_TK_FIRE: begin
                    if (out_free) begin
                        m_kind_reg   <= KIND_FIRE;
                        m_id_reg     <= best_id_reg;
                        m_status_reg <= STAT_OK;
                        m_nexp_reg   <= '0;
                        m_nvalid_reg <= 1'b0;
                        m_last_reg   <= 1'b0;
                        fired_reg[best_idx_reg] <= 1'b1;
                        if (best_period_reg == '0) begin
                            valid_reg[best_idx_reg] <= 1'b0;
                            cnt_reg   <= '0;
                            found_reg <= 1'b0;
                            state_reg <= ST_TK_SCAN;
                        end else begin
                            state_reg <= ST_TK_MUL;
                        end
                    end
                end
                ST_TK_MUL: begin
                    prod_reg  <= PROD_W'(best_period_reg) * PROD_W'(scale_reg);
                    state_reg <= ST_TK_WR;
                end
                ST_TK_WR: begin
                    // memory write of the rearmed slot happens at this edge
                    cnt_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= ST_TK_SCAN;
                end
                ST_NX_SCAN: begin
                    if (scan_end) begin
                        state_reg <= ST_TK_DONE;
                    end
                end
                ST_TK_DONE: begin
                    if (out_free) begin
                        m_kind_reg   <= KIND_DONE;
                        m_id_reg     <= '0;
                        m_status_reg <= STAT_OK;
                        m_nexp_reg   <= found_reg ? best_exp_reg : '0;
                        m_nvalid_reg <= found_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_kind            = m_kind_reg;
    assign m_timer_id        = m_id_reg;
    assign m_status          = m_status_reg;
    assign m_next_expiration = m_nexp_reg;
    assign m_next_valid      = m_nvalid_reg;
    assign m_last            = m_last_reg;

    // issued ids never return to zero
    a_id_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (id_ctr_reg != '0) |=> (id_ctr_reg != '0))
        else $error("id counter returned to zero");

    // only fire words are non-final
    a_nonlast_is_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_kind_reg == KIND_FIRE))
        else $error("non-final result is not a fire");

    // an add never overwrites a live slot
    a_add_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && (state_reg == ST_IDLE)) |-> !valid_reg[mem_waddr])
        else $error("add wrote an occupied slot");

    // a fire word only leaves the tick fire state
    a_fire_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid_reg) && (m_kind_reg == KIND_FIRE)) |-> ($past(state_reg) == ST_TK_FIRE))
        else $error("fire word from wrong state");

endmodule
